// ===== hw/rtl/pmt_pkg.sv =====
package pmt_pkg;

   // Table geometry
   localparam int MAX_LOCKS  = 16;
   localparam int WAIT_DEPTH = 8;
   localparam int KEY_BITS   = 16;
   localparam int PID_BITS   = 16;

   // Field widths on the channels
   localparam int KEY_W = 16;
   localparam int PID_W = 16;

   localparam int LOCK_W    = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
   localparam int CNT_W     = $clog2(WAIT_DEPTH + 1);
   localparam int WQ_DEPTH  = MAX_LOCKS * WAIT_DEPTH;
   localparam int WQ_ADDR_W = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;

   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);
   localparam logic [PID_W-1:0] PID_MASK =
      (PID_BITS >= PID_W) ? {PID_W{1'b1}} : PID_W'((1 << PID_BITS) - 1);

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_ACQUIRE = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_CLOSE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_BUSY      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC,
      S_INS_RD,
      S_INS_CMP,
      S_REL_HEAD,
      S_REL_RD,
      S_REL_MOVE,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type           command;
      logic [KEY_W-1:0]  key_tag;
      logic [PID_W-1:0]  caller_pid;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              caller_blocked;
      logic              wake_valid;
      logic [PID_W-1:0]  wake_pid;
   } result_type;

   // Address of one slot of one lock's wait queue
   function automatic logic [WQ_ADDR_W-1:0] wq_addr(input int lock, input int slot);
      int a;
      a = lock * WAIT_DEPTH + slot;
      return WQ_ADDR_W'(a);
   endfunction

endpackage

// ===== hw/rtl/pmt_if.sv =====
interface pmt_req_if;
   import pmt_pkg::*;

   logic              valid;
   logic              ready;
   cmd_type           command;
   logic [KEY_W-1:0]  key_tag;
   logic [PID_W-1:0]  caller_pid;

   modport source (output valid, command, key_tag, caller_pid, input ready);
   modport sink   (input valid, command, key_tag, caller_pid, output ready);
endinterface

interface pmt_rsp_if;
   import pmt_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic              caller_blocked;
   logic              wake_valid;
   logic [PID_W-1:0]  wake_pid;

   modport source (output valid, status, caller_blocked, wake_valid, wake_pid,
                   input ready);
   modport sink   (input valid, status, caller_blocked, wake_valid, wake_pid,
                   output ready);
endinterface

// ===== hw/rtl/pmt_wait_ram.sv =====
module pmt_wait_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [pmt_pkg::WQ_ADDR_W-1:0]  wr_addr,
   input  logic [pmt_pkg::PID_W-1:0]      wr_data,
   input  logic                           rd_en,
   input  logic [pmt_pkg::WQ_ADDR_W-1:0]  rd_addr,
   output logic [pmt_pkg::PID_W-1:0]      rd_data
);
   import pmt_pkg::*;

   logic [PID_W-1:0] mem [WQ_DEPTH];
   logic [PID_W-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pmt_ctrl.sv =====
module pmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pmt_pkg::req_type     req,
   output logic                 res_done,
   input  logic                 res_take,
   output pmt_pkg::result_type  res
);
   import pmt_pkg::*;

   localparam logic [LOCK_W-1:0] LAST_LOCK = LOCK_W'(MAX_LOCKS - 1);

   // Sequencer and per-transaction registers
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [LOCK_W-1:0] idx_ff, idx_in;
   logic [LOCK_W-1:0] ent_ff, ent_in;
   logic [LOCK_W-1:0] free_ff, free_in;
   logic              found_ff, found_in;
   logic              free_found_ff, free_found_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   status_type        status_ff, status_in;
   logic              blocked_ff, blocked_in;
   logic              wv_ff, wv_in;
   logic [PID_W-1:0]  wp_ff, wp_in;

   // Lock table
   logic              valid_ff [MAX_LOCKS];
   logic              valid_in [MAX_LOCKS];
   logic              owned_ff [MAX_LOCKS];
   logic              owned_in [MAX_LOCKS];
   logic [CNT_W-1:0]  count_ff [MAX_LOCKS];
   logic [CNT_W-1:0]  count_in [MAX_LOCKS];
   logic [KEY_W-1:0]  key_tab_ff [MAX_LOCKS];
   logic [KEY_W-1:0]  key_tab_in [MAX_LOCKS];
   logic [PID_W-1:0]  owner_ff [MAX_LOCKS];
   logic [PID_W-1:0]  owner_in [MAX_LOCKS];

   // Wait queue memory port
   logic                  wq_wr_en;
   logic [WQ_ADDR_W-1:0]  wq_wr_addr;
   logic [PID_W-1:0]      wq_wr_data;
   logic                  wq_rd_en;
   logic [WQ_ADDR_W-1:0]  wq_rd_addr;
   logic [PID_W-1:0]      wq_rd_data;

   logic [CNT_W-1:0]  n_cur;
   logic              pid_above;

   pmt_wait_ram u_wait_ram (
      .clock   (clock),
      .wr_en   (wq_wr_en),
      .wr_addr (wq_wr_addr),
      .wr_data (wq_wr_data),
      .rd_en   (wq_rd_en),
      .rd_addr (wq_rd_addr),
      .rd_data (wq_rd_data)
   );

   assign n_cur     = count_ff[ent_ff];
   // Magnitude compare: queued pid against the caller
   assign pid_above = (wq_rd_data > pid_ff);

   // State register and scalars
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ent_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ent_ff   <= ent_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pid_ff        <= pid_in;
      idx_ff        <= idx_in;
      free_ff       <= free_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      blocked_ff    <= blocked_in;
      wv_ff         <= wv_in;
      wp_ff         <= wp_in;
   end

   // Table registers: control bits reset, payload does not
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LOCKS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
            owned_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end else begin
            valid_ff[i] <= valid_in[i];
            owned_ff[i] <= owned_in[i];
            count_ff[i] <= count_in[i];
         end
         key_tab_ff[i] <= key_tab_in[i];
         owner_ff[i]   <= owner_in[i];
      end
   end

   // Next state and outputs
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pid_in        = pid_ff;
      idx_in        = idx_ff;
      ent_in        = ent_ff;
      free_in       = free_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      blocked_in    = blocked_ff;
      wv_in         = wv_ff;
      wp_in         = wp_ff;
      valid_in      = valid_ff;
      owned_in      = owned_ff;
      count_in      = count_ff;
      key_tab_in    = key_tab_ff;
      owner_in      = owner_ff;
      wq_wr_en      = 1'b0;
      wq_wr_addr    = '0;
      wq_wr_data    = '0;
      wq_rd_en      = 1'b0;
      wq_rd_addr    = '0;
      req_ready     = 1'b0;
      res_done      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in        = req.command;
               key_in        = req.key_tag & KEY_MASK;
               pid_in        = req.caller_pid & PID_MASK;
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SEARCH;
            end
         end

         // One entry per cycle; stop at the first key match
         S_SEARCH: begin
            if (valid_ff[idx_ff] && (key_tab_ff[idx_ff] == key_ff)) begin
               found_in = 1'b1;
               ent_in   = idx_ff;
               state_in = S_EXEC;
            end else begin
               if (!valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = idx_ff;
               end
               if (idx_ff == LAST_LOCK) begin
                  state_in = S_EXEC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_EXEC: begin
            status_in  = ST_OK;
            blocked_in = 1'b0;
            wv_in      = 1'b0;
            wp_in      = '0;
            state_in   = S_DONE;
            if (cmd_ff == CMD_CREATE) begin
               if (!found_ff) begin
                  if (free_found_ff) begin
                     valid_in[free_ff]   = 1'b1;
                     key_tab_in[free_ff] = key_ff;
                     owned_in[free_ff]   = 1'b0;
                     count_in[free_ff]   = '0;
                  end else begin
                     status_in = ST_NO_SPACE;
                  end
               end
            end else if (!found_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               case (cmd_ff)
                  CMD_ACQUIRE: begin
                     if (!owned_ff[ent_ff]) begin
                        owned_in[ent_ff] = 1'b1;
                        owner_in[ent_ff] = pid_ff;
                     end else if (n_cur >= CNT_W'(WAIT_DEPTH)) begin
                        status_in = ST_NO_SPACE;
                     end else begin
                        k_in     = n_cur;
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_RELEASE: begin
                     if (owned_ff[ent_ff] && (owner_ff[ent_ff] == pid_ff)) begin
                        if (n_cur == '0) begin
                           owned_in[ent_ff] = 1'b0;
                        end else begin
                           wq_rd_en   = 1'b1;
                           wq_rd_addr = wq_addr(int'(ent_ff), 0);
                           state_in   = S_REL_HEAD;
                        end
                     end
                  end
                  CMD_CLOSE: begin
                     if (owned_ff[ent_ff]) begin
                        status_in = ST_BUSY;
                     end else begin
                        valid_in[ent_ff] = 1'b0;
                        count_in[ent_ff] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Insert walks from the tail toward the head
         S_INS_RD: begin
            if (k_ff == '0) begin
               wq_wr_en         = 1'b1;
               wq_wr_addr       = wq_addr(int'(ent_ff), 0);
               wq_wr_data       = pid_ff;
               count_in[ent_ff] = n_cur + 1'b1;
               blocked_in       = 1'b1;
               state_in         = S_DONE;
            end else begin
               wq_rd_en   = 1'b1;
               wq_rd_addr = wq_addr(int'(ent_ff), int'(k_ff) - 1);
               state_in   = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            wq_wr_en   = 1'b1;
            wq_wr_addr = wq_addr(int'(ent_ff), int'(k_ff));
            if (pid_above) begin
               wq_wr_data       = pid_ff;
               count_in[ent_ff] = n_cur + 1'b1;
               blocked_in       = 1'b1;
               state_in         = S_DONE;
            end else begin
               wq_wr_data = wq_rd_data;
               k_in       = k_ff - 1'b1;
               state_in   = S_INS_RD;
            end
         end

         // Head of queue becomes the owner; the rest move up one slot
         S_REL_HEAD: begin
            wp_in = wq_rd_data;
            wv_in = 1'b1;
            k_in  = CNT_W'(1);
            if (n_cur == CNT_W'(1)) begin
               count_in[ent_ff] = n_cur - 1'b1;
               owner_in[ent_ff] = wq_rd_data;
               state_in         = S_DONE;
            end else begin
               state_in = S_REL_RD;
            end
         end

         S_REL_RD: begin
            wq_rd_en   = 1'b1;
            wq_rd_addr = wq_addr(int'(ent_ff), int'(k_ff));
            state_in   = S_REL_MOVE;
         end

         S_REL_MOVE: begin
            wq_wr_en   = 1'b1;
            wq_wr_addr = wq_addr(int'(ent_ff), int'(k_ff) - 1);
            wq_wr_data = wq_rd_data;
            k_in       = k_ff + 1'b1;
            if ((k_ff + 1'b1) == n_cur) begin
               count_in[ent_ff] = n_cur - 1'b1;
               owner_in[ent_ff] = wp_ff;
               state_in         = S_DONE;
            end else begin
               state_in = S_REL_RD;
            end
         end

         S_DONE: begin
            res_done = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.status         = status_ff;
   assign res.caller_blocked = blocked_ff;
   assign res.wake_valid     = wv_ff;
   assign res.wake_pid       = wp_ff;

`ifndef SYNTHESIS
   // A queue never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[ent_ff] <= CNT_W'(WAIT_DEPTH))
      else $error("wait queue count over depth");

   // Only a live entry can be owned
   a_owned_valid: assert property (@(posedge clock) disable iff (reset)
      owned_ff[ent_ff] |-> valid_ff[ent_ff])
      else $error("owned lock on a free entry");

   // An accepted transaction always starts with the key search
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SEARCH))
      else $error("accepted transaction did not start search");

   // Queue insert never addresses past the last slot
   a_ins_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (k_ff < CNT_W'(WAIT_DEPTH)))
      else $error("queue insert beyond last slot");

   // A wake is reported only for a release
   a_wake_release: assert property (@(posedge clock) disable iff (reset)
      (res_done && res.wake_valid) |-> (cmd_ff == CMD_RELEASE))
      else $error("wake reported for a non-release command");
`endif

endmodule

// ===== hw/rtl/priority_mutex_table.sv =====
// Table of named mutex locks, each with a wait queue kept in falling pid order.
// req_chan: one transaction carries command (create, acquire, release, close),
//   key_tag and caller_pid. req_chan.ready is high only while the block is idle.
// rsp_chan: exactly one response per request: status, caller_blocked,
//   wake_valid and wake_pid (zero unless a waiter was handed the lock).
// Operation: the key search checks one table entry per cycle and stops at the
//   first match. Queue updates go through a wait RAM with one write port and
//   one registered read port: an insert moves each waiter whose pid is not
//   above the caller's one slot toward the tail, and a release moves each
//   remaining waiter one slot toward the head. ready returns the cycle after
//   the response is loaded.
// The response sits in an output register, so the next request is taken while
//   a response still waits; when rsp_chan stalls with the register full, the
//   finished result is held inside and no new request is taken.
// Reset (synchronous) frees every entry, clears ownership and empties all
//   queues at once; no clearing pass is needed.
module priority_mutex_table (
   input  logic   clock,
   input  logic   reset,
   pmt_req_if.sink   req_chan,
   pmt_rsp_if.source rsp_chan
);
   import pmt_pkg::*;

   req_type     req;
   result_type  res;
   logic        res_done;
   logic        res_take;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   assign req.command    = req_chan.command;
   assign req.key_tag    = req_chan.key_tag;
   assign req.caller_pid = req_chan.caller_pid;

   pmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req       (req),
      .res_done  (res_done),
      .res_take  (res_take),
      .res       (res)
   );

   // Output register: load when empty or being drained
   assign res_take = res_done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.caller_blocked = rsp_data_ff.caller_blocked;
   assign rsp_chan.wake_valid     = rsp_data_ff.wake_valid;
   assign rsp_chan.wake_pid       = rsp_data_ff.wake_pid;

`ifndef SYNTHESIS
   // A result is loaded only into a free or draining register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !res_take)
      else $error("response overwritten while stalled");

   // No request is taken while a result waits inside
   a_no_accept_done: assert property (@(posedge clock) disable iff (reset)
      res_done |-> !req_chan.ready)
      else $error("request taken with a result pending");

   // A wake always carries the no-error status
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.wake_valid) |-> (rsp_data_ff.status == ST_OK))
      else $error("wake with error status");
`endif

endmodule
